// File: design/tdq_pkg.sv
`timescale 1ns / 1ps
// Package for the timer deadline queue: field widths, operation and result codes.
// No dependencies; used by timer_deadline_queue_top.

package tdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;

    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int DL_W    = 48;
    localparam int ID_W    = 32;
    localparam int OWN_W   = 16;
    localparam int SLOT_W  = DL_W + ID_W + OWN_W;
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_START_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL_ACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE       = 2'd3;

    localparam logic [ID_W-1:0] ID_FIRST = 32'd1;

endpackage

// File: design/tdq_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module tdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/timer_deadline_queue_top.sv
`timescale 1ns / 1ps
// Timer deadline queue top level: slot RAM, valid and age ranks, scan sequencer.
// Depends on tdq_pkg and tdq_ram.

// Holds up to DEPTH timers; deadline, id and owner sit in one RAM, valid bits and
// age ranks in flip-flops, so no clearing pass follows reset. One word is handled
// at a time. Cancel and poll scan the RAM through its single read port, one slot
// per cycle. A poll rescans the RAM once for each timer that it expires and stops
// at MAX_RESULTS timers; the rest stay for a later poll. A result waits in an
// output register while the next scan runs; back-pressure on the result side
// stalls the sequencer until the result is taken.

module timer_deadline_queue_top #(
    parameter int DEPTH = tdq_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // deadline_us[47:0], owner[63:48], cancel_id[95:64], now_us[143:96]
    input  logic [tdq_pkg::IN_DATA_W-1:0]    s_tdata,
    // op[1:0]
    input  logic [tdq_pkg::OP_W-1:0]         s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[0], timer_id[32:1], expired_owner[48:33], zero[55:49]
    output logic [tdq_pkg::OUT_DATA_W-1:0]   m_tdata,
    // kind[1:0]
    output logic [tdq_pkg::KIND_W-1:0]       m_tuser,
    output logic                             m_tlast
);

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int DL_W = tdq_pkg::DL_W;
    localparam int ID_W = tdq_pkg::ID_W;
    localparam int OWN_W = tdq_pkg::OWN_W;
    localparam int RES_W = tdq_pkg::RES_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [tdq_pkg::OP_W-1:0] op_reg, op_next;
    logic [DL_W-1:0]  deadline_reg, deadline_next;
    logic [OWN_W-1:0] owner_reg, owner_next;
    logic [ID_W-1:0]  cancel_id_reg, cancel_id_next;
    logic [DL_W-1:0]  now_reg, now_next;

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [IDXW-1:0]  order_reg [DEPTH];
    logic [IDXW-1:0]  order_next [DEPTH];
    logic [CNTW-1:0]  count_reg, count_next;
    logic [ID_W-1:0]  next_id_reg, next_id_next;

    logic [IDXW-1:0]  scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             rd_last_reg, rd_last_next;
    logic [IDXW-1:0]  rd_idx_reg, rd_idx_next;

    logic             found_reg, found_next;
    logic [IDXW-1:0]  best_idx_reg, best_idx_next;
    logic [DL_W-1:0]  best_dl_reg, best_dl_next;
    logic [IDXW-1:0]  best_ord_reg, best_ord_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;
    logic [OWN_W-1:0] best_own_reg, best_own_next;

    logic             pend_vld_reg, pend_vld_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;
    logic [OWN_W-1:0] pend_own_reg, pend_own_next;
    logic [RES_W-1:0] n_reg, n_next;

    logic                        out_vld_reg, out_vld_next;
    logic [tdq_pkg::KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic                        out_status_reg, out_status_next;
    logic [ID_W-1:0]             out_id_reg, out_id_next;
    logic [OWN_W-1:0]            out_own_reg, out_own_next;
    logic                        out_last_reg, out_last_next;

    logic                        ram_we;
    logic [IDXW-1:0]             ram_waddr;
    logic [tdq_pkg::SLOT_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [tdq_pkg::SLOT_W-1:0]  ram_rdata;

    logic             out_free;
    logic [IDXW-1:0]  free_idx;
    logic [DL_W-1:0]  rd_dl;
    logic [ID_W-1:0]  rd_id;
    logic [OWN_W-1:0] rd_own;
    logic [IDXW-1:0]  rd_ord;
    logic             rd_match;
    logic             rd_earlier;
    logic             remove_en;

    tdq_ram #(
        .WIDTH (tdq_pkg::SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(tdq_pkg::OUT_DATA_W - 1 - ID_W - OWN_W){1'b0}},
                       out_own_reg, out_id_reg, out_status_reg};

    assign out_free = !out_vld_reg || m_tready;

    assign rd_dl  = ram_rdata[DL_W-1:0];
    assign rd_id  = ram_rdata[DL_W+ID_W-1:DL_W];
    assign rd_own = ram_rdata[tdq_pkg::SLOT_W-1:DL_W+ID_W];
    assign rd_ord = order_reg[rd_idx_reg];

    assign rd_match = valid_reg[rd_idx_reg] &&
                      ((op_reg == tdq_pkg::OP_CANCEL) ? (rd_id == cancel_id_reg)
                                                      : (rd_dl <= now_reg));
    assign rd_earlier = !found_reg || (rd_dl < best_dl_reg) ||
                        ((rd_dl == best_dl_reg) && (rd_ord < best_ord_reg));

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDXW'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        deadline_next   = deadline_reg;
        owner_next      = owner_reg;
        cancel_id_next  = cancel_id_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        order_next      = order_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        rd_last_next    = 1'b0;
        rd_idx_next     = scan_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        best_ord_next   = best_ord_reg;
        best_id_next    = best_id_reg;
        best_own_next   = best_own_reg;
        pend_vld_next   = pend_vld_reg;
        pend_id_next    = pend_id_reg;
        pend_own_next   = pend_own_reg;
        n_next          = n_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_own_next    = out_own_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = free_idx;
        ram_wdata       = {owner_reg, next_id_reg, deadline_reg};
        ram_re          = 1'b0;
        remove_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = s_tuser;
                    deadline_next   = s_tdata[47:0];
                    owner_next      = s_tdata[63:48];
                    cancel_id_next  = s_tdata[95:64];
                    now_next        = s_tdata[143:96];
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    pend_vld_next   = 1'b0;
                    n_next          = '0;
                    case (s_tuser)
                        tdq_pkg::OP_START:  state_next = ST_START;
                        tdq_pkg::OP_CANCEL: state_next = ST_SCAN;
                        tdq_pkg::OP_POLL:   state_next = ST_SCAN;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end

            ST_START:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = tdq_pkg::KIND_START_ACK;
                    out_own_next  = '0;
                    out_last_next = 1'b1;
                    if (count_reg == CNTW'(DEPTH))
                    begin
                        out_status_next = 1'b1;
                        out_id_next     = '0;
                    end
                    else
                    begin
                        ram_we               = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        order_next[free_idx] = count_reg[IDXW-1:0];
                        count_next           = count_reg + CNTW'(1);
                        next_id_next         = next_id_reg + ID_W'(1);
                        out_status_next      = 1'b0;
                        out_id_next          = next_id_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    ram_re       = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_last_next = (scan_idx_reg == IDXW'(DEPTH - 1));
                    if (scan_idx_reg == IDXW'(DEPTH - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDXW'(1);
                    end
                end
                if (rd_vld_reg && rd_match && rd_earlier)
                begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_dl_next  = rd_dl;
                    best_ord_next = rd_ord;
                    best_id_next  = rd_id;
                    best_own_next = rd_own;
                end
                if (rd_vld_reg && rd_last_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (op_reg == tdq_pkg::OP_CANCEL)
                begin
                    if (out_free)
                    begin
                        out_vld_next    = 1'b1;
                        out_kind_next   = tdq_pkg::KIND_CANCEL_ACK;
                        out_status_next = !found_reg;
                        out_id_next     = cancel_id_reg;
                        out_own_next    = '0;
                        out_last_next   = 1'b1;
                        remove_en       = found_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else if (found_reg)
                begin
                    if (!pend_vld_reg || out_free)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next    = 1'b1;
                            out_kind_next   = tdq_pkg::KIND_EXPIRED;
                            out_status_next = 1'b0;
                            out_id_next     = pend_id_reg;
                            out_own_next    = pend_own_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_vld_next   = 1'b1;
                        pend_id_next    = best_id_reg;
                        pend_own_next   = best_own_reg;
                        remove_en       = 1'b1;
                        n_next          = n_reg + RES_W'(1);
                        scan_idx_next   = '0;
                        issue_done_next = 1'b0;
                        found_next      = 1'b0;
                        if (n_reg == RES_W'(tdq_pkg::MAX_RESULTS - 1))
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
                else if (pend_vld_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_kind_next   = tdq_pkg::KIND_NONE;
                    out_status_next = 1'b0;
                    out_id_next     = '0;
                    out_own_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_kind_next   = tdq_pkg::KIND_EXPIRED;
                    out_status_next = 1'b0;
                    out_id_next     = pend_id_reg;
                    out_own_next    = pend_own_reg;
                    out_last_next   = 1'b1;
                    pend_vld_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // drop the chosen slot and close the gap in the age ranks
        if (remove_en)
        begin
            valid_next[best_idx_reg] = 1'b0;
            count_next               = count_reg - CNTW'(1);
            for (int j = 0; j < DEPTH; j++)
            begin
                if (valid_reg[j] && (order_reg[j] > best_ord_reg))
                begin
                    order_next[j] = order_reg[j] - IDXW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            next_id_reg    <= tdq_pkg::ID_FIRST;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            found_reg      <= 1'b0;
            pend_vld_reg   <= 1'b0;
            n_reg          <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            rd_last_reg    <= rd_last_next;
            found_reg      <= found_next;
            pend_vld_reg   <= pend_vld_next;
            n_reg          <= n_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        deadline_reg   <= deadline_next;
        owner_reg      <= owner_next;
        cancel_id_reg  <= cancel_id_next;
        now_reg        <= now_next;
        order_reg      <= order_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_dl_reg    <= best_dl_next;
        best_ord_reg   <= best_ord_next;
        best_id_reg    <= best_id_next;
        best_own_reg   <= best_own_next;
        pend_id_reg    <= pend_id_next;
        pend_own_reg   <= pend_own_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_own_reg    <= out_own_next;
        out_last_reg   <= out_last_next;
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNTW'($countones(valid_reg)))
        else $error("live count differs from valid bits");

    a_write_only_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_START))
        else $error("slot RAM written outside a start");

    a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> pend_vld_reg)
        else $error("flush without a pending expired timer");

    a_results_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RES_W'(tdq_pkg::MAX_RESULTS))
        else $error("too many expired timers in one poll");

    a_remove_live_slot: assert property (@(posedge clk) disable iff (!rst_n)
        remove_en |-> valid_reg[best_idx_reg])
        else $error("removing a slot that is not live");

endmodule
